### sv/url_marker_ipv4_extractor_defines.svh
// Assertion helpers shared by the extractor RTL.
`ifndef URL_MARKER_IPV4_EXTRACTOR_DEFINES_SVH
`define URL_MARKER_IPV4_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UMIE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define UMIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/umie_pkg.sv
package umie_pkg;

	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 32;
	localparam int SEEN_W   = 3;
	localparam int MATCH_W  = 2;
	localparam int OCTET_W  = 8;
	localparam int IDX_W    = 3;
	// accumulator * 10 + digit fits in 12 bits
	localparam int ACC_EXT_W = 12;

	localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h27;
	localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

	// marker position codes
	localparam logic [MATCH_W-1:0] MATCH_NONE  = 2'd0;
	localparam logic [MATCH_W-1:0] MATCH_COLON = 2'd1;
	localparam logic [MATCH_W-1:0] MATCH_LAST  = 2'd2;
	localparam logic [MATCH_W-1:0] MATCH_BAD   = 2'd3;

	// octet index codes
	localparam logic [IDX_W-1:0] IDX_FIRST  = 3'd0;
	localparam logic [IDX_W-1:0] IDX_SECOND = 3'd1;
	localparam logic [IDX_W-1:0] IDX_THIRD  = 3'd2;
	localparam logic [IDX_W-1:0] IDX_FOURTH = 3'd3;
	localparam logic [IDX_W-1:0] IDX_EXTRA  = 3'd4;

	localparam logic [SEEN_W-1:0] SEEN_MAX = 3'd4;
	localparam logic [ACC_EXT_W-1:0] OCTET_MAX = 12'd255;

	// expected marker byte at a given match position
	function automatic logic [BYTE_W-1:0] mark_char(input logic [MATCH_W-1:0] pos);
		logic [BYTE_W-1:0] ch;
		case (pos)
			MATCH_NONE:  ch = CHAR_COLON;
			MATCH_COLON: ch = CHAR_SLASH;
			MATCH_LAST:  ch = CHAR_SLASH;
			default:     ch = CHAR_COLON;
		endcase
		return ch;
	endfunction

endpackage

### sv/umie_if.sv
interface umie_rx_if import umie_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface umie_res_if import umie_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  ip_address;
	logic [SEEN_W-1:0]  octets_seen;
	logic               malformed;

	modport source (output valid, output ip_address, output octets_seen, output malformed,
		input ready);
	modport sink   (input valid, input ip_address, input octets_seen, input malformed,
		output ready);
endinterface

### sv/url_marker_ipv4_extractor.sv
// Scans a byte stream for the marker "://" and parses the dotted-decimal text after it as an
// IPv4 address; a single-quote byte ends the address and produces one result word (address
// with the first octet in bits 31..24, number of octets seen, malformed flag), after which
// the marker search starts over. Bytes that cause no result produce nothing. Each byte is
// registered on input and handled once the result register can advance, by one compare and
// multiply-by-ten step into the parser state, so the block takes one byte per clock; the
// only limit is the result register, which holds a finished word until the sink takes it
// while one more byte waits in the input register. An accepted quote byte passes through the
// input register and then the result register on its way to the result word.
`include "url_marker_ipv4_extractor_defines.svh"

module url_marker_ipv4_extractor import umie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	umie_rx_if.sink     rx,
	umie_res_if.source  res
);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parser state
	logic [MATCH_W-1:0] match_q;
	logic               capturing_q;
	logic [OCTET_W-1:0] acc_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [IDX_W-1:0]   idx_q;
	logic               err_q;

	// result register
	logic              out_valid_q;
	logic [ADDR_W-1:0] ip_q;
	logic [SEEN_W-1:0] seen_q;
	logic              bad_q;

	// next-state values
	logic [MATCH_W-1:0] match_d;
	logic               capturing_d;
	logic [OCTET_W-1:0] acc_d;
	logic [ADDR_W-1:0]  addr_d;
	logic [IDX_W-1:0]   idx_d;
	logic               err_d;
	logic               hit;
	logic [ADDR_W-1:0]  ip_d;
	logic [SEEN_W-1:0]  seen_d;

	logic               advance;
	logic               step;
	logic [ADDR_W-1:0]  placed;
	logic [ACC_EXT_W-1:0] acc_ext;
	logic [ACC_EXT_W-1:0] mul;
	logic               is_digit;

	// result slot is free or drains this cycle
	assign advance  = !out_valid_q || res.ready;
	assign step     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign acc_ext  = {{(ACC_EXT_W-OCTET_W){1'b0}}, acc_q};
	// acc*10 + digit as two shifts and adds
	assign mul = (acc_ext << 3) + (acc_ext << 1)
		+ {{(ACC_EXT_W-4){1'b0}}, byte_s1[3:0]};

	// current octet placed at its byte lane
	always_comb begin
		case (idx_q)
			IDX_FIRST:  placed = {acc_q, 24'b0};
			IDX_SECOND: placed = {8'b0, acc_q, 16'b0};
			IDX_THIRD:  placed = {16'b0, acc_q, 8'b0};
			IDX_FOURTH: placed = {24'b0, acc_q};
			default:    placed = '0;
		endcase
	end

	always_comb begin
		match_d     = match_q;
		capturing_d = capturing_q;
		acc_d       = acc_q;
		addr_d      = addr_q;
		idx_d       = idx_q;
		err_d       = err_q;
		hit         = 1'b0;
		ip_d        = addr_q | placed;
		seen_d      = idx_q[2] ? SEEN_MAX : idx_q + 3'd1;

		if (!capturing_q) begin
			if (match_q != MATCH_BAD && byte_s1 == mark_char(match_q)) begin
				if (match_q == MATCH_LAST) begin
					match_d     = MATCH_NONE;
					capturing_d = 1'b1;
					acc_d       = '0;
					addr_d      = '0;
					idx_d       = IDX_FIRST;
					err_d       = 1'b0;
				end else begin
					match_d = match_q + 2'd1;
				end
			end else if (byte_s1 == CHAR_COLON) begin
				match_d = MATCH_COLON;
			end else begin
				match_d = MATCH_NONE;
			end
		end else if (byte_s1 == CHAR_QUOTE) begin
			hit         = 1'b1;
			capturing_d = 1'b0;
			match_d     = MATCH_NONE;
			acc_d       = '0;
			addr_d      = '0;
			idx_d       = IDX_FIRST;
			err_d       = 1'b0;
		end else if (byte_s1 == CHAR_DOT) begin
			if (!idx_q[2]) begin
				addr_d = addr_q | placed;
				acc_d  = '0;
				idx_d  = idx_q + 3'd1;
				if (idx_q == IDX_FOURTH) begin
					err_d = 1'b1;
				end
			end else begin
				err_d = 1'b1;
			end
		end else if (is_digit) begin
			if (!idx_q[2]) begin
				if (mul > OCTET_MAX) begin
					acc_d = OCTET_MAX[OCTET_W-1:0];
					err_d = 1'b1;
				end else begin
					acc_d = mul[OCTET_W-1:0];
				end
			end
		end else begin
			err_d = 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= MATCH_NONE;
			capturing_q <= 1'b0;
			acc_q       <= '0;
			addr_q      <= '0;
			idx_q       <= IDX_FIRST;
			err_q       <= 1'b0;
		end else if (step) begin
			match_q     <= match_d;
			capturing_q <= capturing_d;
			acc_q       <= acc_d;
			addr_q      <= addr_d;
			idx_q       <= idx_d;
			err_q       <= err_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit) begin
			ip_q   <= ip_d;
			seen_q <= seen_d;
			bad_q  <= err_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.ip_address  = ip_q;
	assign res.octets_seen = seen_q;
	assign res.malformed   = bad_q;

	// capture state stays cleared while searching for the marker
	`UMIE_ASSERT_IMPL(a_search_clean, clk, arst_n, !capturing_q,
		acc_q == '0 && addr_q == '0 && idx_q == IDX_FIRST && !err_q,
		"capture state not clear during marker search")

	// marker position never reaches the unused code, octet index never past the extra octet
	`UMIE_ASSERT_IMPL(a_codes_range, clk, arst_n, 1'b1,
		match_q != MATCH_BAD && (!idx_q[2] || idx_q[1:0] == 2'b00),
		"parser position out of range")

	// every result word reports between one and four octets
	`UMIE_ASSERT_IMPL(a_seen_range, clk, arst_n, out_valid_q,
		seen_q != '0 && seen_q <= SEEN_MAX, "octet count out of range")

	// a quote byte handled while capturing returns the parser to the marker search
	`UMIE_ASSERT_NEXT(a_quote_ends, clk, arst_n,
		step && capturing_q && byte_s1 == CHAR_QUOTE,
		!capturing_q && out_valid_q, "quote did not close the address")

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import umie_pkg::*;

	// One result word as it leaves the block
	typedef struct packed {
		logic [ADDR_W-1:0] ip_address;
		logic [SEEN_W-1:0] octets_seen;
		logic              malformed;
	} addr_word_t;

	localparam int HOLD_AT     = 500;   // cycle after reset at which the sink holds off
	localparam int HOLD_LEN    = 300;   // length of that hold-off
	localparam int QUIET_FROM  = 1200;  // window with no random idling on either side
	localparam int QUIET_TO    = 1700;
	localparam int STALL_LIMIT = 2000;  // cycles with no word moving before giving up
	localparam int N_BYTES     = 1600;

	logic clk;
	logic arst_n;

	umie_rx_if  rx_ch ();
	umie_res_if res_ch ();

	url_marker_ipv4_extractor uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	logic [BYTE_W-1:0] byte_q[$];  // bytes still to send
	addr_word_t        addr_q[$];  // addresses predicted, not yet seen at the output
	int                fails;
	int                cyc;
	int                hold_left;
	int                stall_cnt;
	logic              quiet;

	// Predictor state: marker search and address capture
	logic [MATCH_W-1:0] scan_pos;
	logic               in_addr;
	logic [OCTET_W-1:0] cur_octet;
	logic [ADDR_W-1:0]  addr_acc;
	logic [IDX_W-1:0]   oct_idx;
	logic               bad_seen;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic clear_addr();
		cur_octet = '0;
		addr_acc  = '0;
		oct_idx   = IDX_FIRST;
		bad_seen  = 1'b0;
	endtask

	// Merge the open octet into the address; nothing past the fourth octet lands
	task automatic merge_octet();
		if (oct_idx != IDX_EXTRA)
			addr_acc = addr_acc | ({24'b0, cur_octet} << (8 * (IDX_FOURTH - oct_idx)));
	endtask

	// Advance the predicted state by one accepted byte; a quote during capture
	// yields one expected word.
	task automatic track_byte(input logic [BYTE_W-1:0] c);
		logic [ACC_EXT_W-1:0] sum;
		addr_word_t           w;
		if (!in_addr) begin
			// wrong byte falls back to position 1 on a colon, else to 0
			if (scan_pos == MATCH_NONE && c == CHAR_COLON)
				scan_pos = MATCH_COLON;
			else if (scan_pos == MATCH_COLON && c == CHAR_SLASH)
				scan_pos = MATCH_LAST;
			else if (scan_pos == MATCH_LAST && c == CHAR_SLASH) begin
				scan_pos = MATCH_NONE;
				in_addr  = 1'b1;
				clear_addr();
			end else
				scan_pos = (c == CHAR_COLON) ? MATCH_COLON : MATCH_NONE;
		end else if (c == CHAR_QUOTE) begin
			merge_octet();
			w.ip_address  = addr_acc;
			w.octets_seen = (oct_idx == IDX_EXTRA) ? SEEN_MAX : SEEN_W'(oct_idx + 1);
			w.malformed   = bad_seen;
			addr_q.push_back(w);
			in_addr  = 1'b0;
			scan_pos = MATCH_NONE;
			clear_addr();
		end else if (c == CHAR_DOT) begin
			if (oct_idx != IDX_EXTRA) begin
				merge_octet();
				// dot on the fourth octet opens a fifth: flagged
				if (oct_idx == IDX_FOURTH)
					bad_seen = 1'b1;
				oct_idx   = oct_idx + 3'd1;
				cur_octet = '0;
			end else
				bad_seen = 1'b1;
		end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			if (oct_idx != IDX_EXTRA) begin
				sum = ACC_EXT_W'(cur_octet) * ACC_EXT_W'(10) + ACC_EXT_W'(c - CHAR_ZERO);
				if (sum > OCTET_MAX) begin
					sum      = OCTET_MAX;  // saturate, flag
					bad_seen = 1'b1;
				end
				cur_octet = sum[OCTET_W-1:0];
			end
		end else
			bad_seen = 1'b1;  // any other character
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			byte_q.push_back(s[i]);
	endtask

	// Stimulus build, reset, and end of run
	initial begin
		int    n_oct;
		string s;
		arst_n = 1'b0;

		// Directed: all-ones and all-zeros bytes while searching, colon restart
		byte_q.push_back(8'hFF);
		byte_q.push_back(8'h00);
		push_text("::/");
		// completes the marker; then overflow, empty octet, fifth octet, ignored digit
		push_text("/1.300..255.9'");
		// empty address, then a bad character
		push_text("://'");
		push_text("://x'");

		// Random: mostly well-formed addresses behind the marker, some noise
		while (byte_q.size() < N_BYTES) begin
			repeat ($urandom_range(0, 3)) begin
				case ($urandom_range(0, 5))
					0: byte_q.push_back(CHAR_COLON);
					1: byte_q.push_back(CHAR_SLASH);
					2: byte_q.push_back(CHAR_QUOTE);
					default: byte_q.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			// occasionally a broken marker
			if ($urandom_range(0, 9) == 0)
				push_text(":/");
			push_text("://");
			n_oct = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
			for (int k = 0; k < n_oct; k++) begin
				if (k != 0)
					byte_q.push_back(CHAR_DOT);
				case ($urandom_range(0, 19))
					0: s = "";
					1: s = $sformatf("%0d", $urandom_range(256, 999));
					2: s = $sformatf("0%0d", $urandom_range(0, 255));
					3: s = $sformatf("%0d", $urandom_range(25, 26) * 10 + $urandom_range(0, 9));
					default: s = $sformatf("%0d", $urandom_range(0, 255));
				endcase
				push_text(s);
				if ($urandom_range(0, 29) == 0)
					byte_q.push_back(8'($urandom_range(0, 255)));
			end
			// a missing quote lets the capture run on into the next noise
			if ($urandom_range(0, 29) != 0)
				byte_q.push_back(CHAR_QUOTE);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || rx_ch.valid || addr_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("url_marker_ipv4_extractor test passed");
		else
			$display("url_marker_ipv4_extractor test failed");
		$finish;
	end

	// Cycle count since reset; sets the quiet window
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc   <= 0;
			quiet <= 1'b0;
		end else begin
			cyc   <= cyc + 1;
			quiet <= (cyc >= QUIET_FROM && cyc < QUIET_TO);
		end
	end

	// Byte driver: predicts on acceptance, then offers the next byte or idles.
	// valid stays up while the block stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= '0;
			scan_pos = MATCH_NONE;
			in_addr  = 1'b0;
			clear_addr();
		end else begin
			if (rx_ch.valid && rx_ch.ready)
				track_byte(rx_ch.rx_byte);
			if (!rx_ch.valid || rx_ch.ready) begin
				if (byte_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= byte_q.pop_front();
				end else
					rx_ch.valid <= 1'b0;
			end
		end
	end

	// Sink ready: random gaps, plus one long hold-off so results back up
	// and the block stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left    <= 0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (cyc == HOLD_AT) begin
			hold_left    <= HOLD_LEN;
			res_ch.ready <= 1'b0;
		end else
			res_ch.ready <= quiet || ($urandom_range(0, 99) >= 9);
	end

	// Result monitor: each accepted word against the oldest predicted address
	always @(posedge clk) begin : mon_blk
		addr_word_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (addr_q.size() == 0) begin
				$error("unexpected word: ip_address %h octets_seen %0d malformed %0b",
					res_ch.ip_address, res_ch.octets_seen, res_ch.malformed);
				fails++;
			end else begin
				w = addr_q.pop_front();
				if (res_ch.ip_address !== w.ip_address) begin
					$error("ip_address: expected %h, got %h", w.ip_address, res_ch.ip_address);
					fails++;
				end
				if (res_ch.octets_seen !== w.octets_seen) begin
					$error("octets_seen: expected %0d, got %0d", w.octets_seen,
						res_ch.octets_seen);
					fails++;
				end
				if (res_ch.malformed !== w.malformed) begin
					$error("malformed: expected %0b, got %0b", w.malformed, res_ch.malformed);
					fails++;
				end
			end
		end
	end

	// Watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cnt <= 0;
		else if (stall_cnt >= STALL_LIMIT) begin
			$display("url_marker_ipv4_extractor test failed");
			$finish;
		end else
			stall_cnt <= stall_cnt + 1;
	end

endmodule
